// ----- hdl/gmig_pkg.sv -----
// Shared types and constants for the grid mesh index generator.
`timescale 1ns / 1ps

package gmig_pkg;

  localparam int SIDE_W   = 9;
  localparam int COORD_W  = 8;
  localparam int INDEX_W  = 16;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [SIDE_W-1:0]    side_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t CFG_GRID_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_GRID_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_MESH_MODE   = 2'd2;

  // Mesh modes
  localparam logic MODE_STRIP = 1'b0;
  localparam logic MODE_QUAD  = 1'b1;

  // Quad corner codes
  localparam logic [PHASE_W-1:0] CORNER_TL = 2'd0;
  localparam logic [PHASE_W-1:0] CORNER_BL = 2'd1;
  localparam logic [PHASE_W-1:0] CORNER_BR = 2'd2;
  localparam logic [PHASE_W-1:0] CORNER_TR = 2'd3;

  typedef struct packed {
    coord_t             row_count;
    coord_t             column_count;
    logic [PHASE_W-1:0] phase;
    logic               in_degenerate;
  } pos_t;

  localparam pos_t POS_START = '0;

  typedef struct packed {
    index_t vertex_index;
    coord_t vertex_column;
    coord_t vertex_row;
    logic   degenerate;
    logic   last;
  } result_t;

endpackage

// ----- hdl/gmig_step.sv -----
// Next-position and vertex logic for one word of the mesh index sequence.
`timescale 1ns / 1ps

module gmig_step (
  input  gmig_pkg::pos_t    pos,
  input  logic              restart,
  input  logic              mesh_mode,
  input  gmig_pkg::side_t   side_w,
  input  gmig_pkg::side_t   side_h,
  output gmig_pkg::pos_t    pos_nxt,
  output gmig_pkg::result_t result
);
  import gmig_pkg::*;

  side_t              row_v;
  side_t              col_v;
  logic               degen_v;
  logic               fin_v;
  logic [SIDE_W+COORD_W-1:0] prod;

  always_comb begin
    pos_t               cur;
    side_t              w_m1;
    side_t              w_m2;
    side_t              h_m1;
    side_t              h_m2;
    side_t              x;
    side_t              y;
    side_t              x_inc;
    side_t              y_inc;
    side_t              k_inc;
    logic               odd;
    logic               top;
    logic [PHASE_W-1:0] ph;
    logic               in_deg;

    cur = restart ? POS_START : pos;
    w_m1 = side_w - 9'd1;
    w_m2 = side_w - 9'd2;
    h_m1 = side_h - 9'd1;
    h_m2 = side_h - 9'd2;
    x = {1'b0, cur.column_count};
    y = {1'b0, cur.row_count};
    ph = cur.phase;
    in_deg = cur.in_degenerate;
    row_v = '0;
    col_v = '0;
    degen_v = 1'b0;
    fin_v = 1'b0;
    odd = 1'b0;
    top = 1'b0;
    x_inc = '0;
    y_inc = '0;
    k_inc = '0;

    if (mesh_mode == MODE_QUAD) begin
      if (x > w_m2 || y > h_m2) begin
        x = '0;
        y = '0;
      end
      unique case (ph)
        CORNER_TL: begin row_v = y;        col_v = x;        end
        CORNER_BL: begin row_v = y + 9'd1; col_v = x;        end
        CORNER_BR: begin row_v = y + 9'd1; col_v = x + 9'd1; end
        CORNER_TR: begin row_v = y;        col_v = x + 9'd1; end
        default:   begin row_v = y;        col_v = x;        end
      endcase
      if (ph == CORNER_TR) begin
        fin_v = (x == w_m2) && (y == h_m2);
        ph = CORNER_TL;
        x_inc = x + 9'd1;
        if (x_inc == w_m1) begin
          x = '0;
          y_inc = y + 9'd1;
          y = (y_inc == h_m1) ? '0 : y_inc;
        end else begin
          x = x_inc;
        end
      end else begin
        ph = ph + 2'd1;
      end
      in_deg = 1'b0;
    end else begin
      // x is the step along the strip, y the strip number
      if (y > h_m2 || x > w_m1) begin
        y = '0;
        x = '0;
        in_deg = 1'b0;
        ph = '0;
      end
      odd = y[0];
      if (in_deg) begin
        degen_v = 1'b1;
        col_v = odd ? '0 : w_m1;
        if (!ph[0]) begin
          row_v = odd ? y : y + 9'd1;
          ph = 2'd1;
        end else begin
          row_v = y + 9'd1;
          ph = '0;
          in_deg = 1'b0;
          y = y + 9'd1;
          x = '0;
        end
      end else begin
        col_v = odd ? (w_m1 - x) : x;
        top = (!ph[0]) != odd;
        row_v = top ? y : y + 9'd1;
        if (!ph[0]) begin
          ph = 2'd1;
        end else begin
          ph = '0;
          k_inc = x + 9'd1;
          if (k_inc == side_w) begin
            x = '0;
            // enter the degenerate pair unless this was the final strip
            if (y + 9'd2 < side_h) begin
              in_deg = 1'b1;
            end else begin
              fin_v = 1'b1;
              y = '0;
            end
          end else begin
            x = k_inc;
          end
        end
      end
    end

    pos_nxt.row_count     = y[COORD_W-1:0];
    pos_nxt.column_count  = x[COORD_W-1:0];
    pos_nxt.phase         = ph;
    pos_nxt.in_degenerate = in_deg;
  end

  assign prod = row_v[COORD_W-1:0] * side_w;

  always_comb begin
    result.vertex_index  = prod[INDEX_W-1:0] + {{(INDEX_W-COORD_W){1'b0}}, col_v[COORD_W-1:0]};
    result.vertex_column = col_v[COORD_W-1:0];
    result.vertex_row    = row_v[COORD_W-1:0];
    result.degenerate    = degen_v;
    result.last          = fin_v;
  end

endmodule

// ----- hdl/grid_mesh_index_generator.sv -----
// Top level of the grid mesh index generator: registers, handshakes, output stage.
`timescale 1ns / 1ps

// Channel | Direction | Word contents
// in_     | slave     | tdata[0] restart, tdata[7:1] zero
// out_    | master    | tdata vertex_index/column/row, tuser degenerate, tlast end of mesh
// cfg_    | slave     | index 0 grid_width, 1 grid_height, 2 mesh_mode; data[8:0]
//
// One word in and one word out per cycle while out_ is not stalled; a word appears on out_
// in the cycle after it is taken, through the single output register that also holds it
// under backpressure. in_tready drops only while a held output word is not being taken.
// Synchronous reset returns width 2, height 2, strip mode and the start of the sequence.
// A write to grid_width, grid_height or mesh_mode returns the sequence to its start; cfg_ready is always high.

module grid_mesh_index_generator #(
  parameter int MAX_GRID_SIDE = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [0] restart
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // [15:0] vertex_index, [23:16] vertex_column,
                                                // [31:24] vertex_row
  output logic                      out_tuser,  // [0] degenerate
  output logic                      out_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gmig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gmig_pkg::SIDE_W-1:0]    cfg_data
);
  import gmig_pkg::*;

  localparam int SIDE_CAP = (MAX_GRID_SIDE < 256) ? MAX_GRID_SIDE : 256;
  localparam int SIDE_HI  = (SIDE_CAP < 2) ? 2 : SIDE_CAP;

  side_t   grid_width_r;
  side_t   grid_height_r;
  logic    mesh_mode_r;
  pos_t    pos_r;
  pos_t    pos_nxt;
  result_t step_res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_fire;
  logic    cfg_fire;
  logic    cfg_hit;
  side_t   side_w;
  side_t   side_h;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == CFG_GRID_WIDTH || cfg_index == CFG_GRID_HEIGHT
                                  || cfg_index == CFG_MESH_MODE);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // saturate the side registers into the supported range
  always_comb begin
    if (grid_width_r < 9'd2) begin
      side_w = 9'd2;
    end else if (grid_width_r > SIDE_W'(SIDE_HI)) begin
      side_w = SIDE_W'(SIDE_HI);
    end else begin
      side_w = grid_width_r;
    end
    if (grid_height_r < 9'd2) begin
      side_h = 9'd2;
    end else if (grid_height_r > SIDE_W'(SIDE_HI)) begin
      side_h = SIDE_W'(SIDE_HI);
    end else begin
      side_h = grid_height_r;
    end
  end

  gmig_step u_step (
    .pos       (pos_r),
    .restart   (in_tdata[0]),
    .mesh_mode (mesh_mode_r),
    .side_w    (side_w),
    .side_h    (side_h),
    .pos_nxt   (pos_nxt),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 9'd2;
      grid_height_r <= 9'd2;
      mesh_mode_r   <= MODE_STRIP;
      pos_r         <= POS_START;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
          CFG_MESH_MODE:   mesh_mode_r   <= cfg_data[0];
          default:         ;
        endcase
      end
      priority if (cfg_hit) begin
        pos_r <= POS_START;
      end else if (in_fire) begin
        pos_r <= pos_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the output word until it is taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.vertex_row, res_r.vertex_column, res_r.vertex_index};
  assign out_tuser  = res_r.degenerate;
  assign out_tlast  = res_r.last;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the grid mesh index generator: stream driver, sink and scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import gmig_pkg::*;

  localparam int SIDE_CAP     = 256;   // largest side the block uses
  localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake
  localparam int RANDOM_WORDS = 1100;
  localparam int TAIL_CYCLES  = 10;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // Scoreboard: tracks the mesh position and holds the expected index words
  class mesh_index_scoreboard;
    side_t     width_reg;
    side_t     height_reg;
    logic      mode_reg;
    int        row_cnt;
    int        col_cnt;
    int        corner;
    bit        in_degen;
    result_t   expected_indices[$];
    int        mismatches;

    function new();
      width_reg  = 9'd2;
      height_reg = 9'd2;
      mode_reg   = MODE_STRIP;
      mismatches = 0;
      rewind();
    endfunction

    function void rewind();
      row_cnt  = 0;
      col_cnt  = 0;
      corner   = 0;
      in_degen = 0;
    endfunction

    function int used_side(side_t v);
      if (v < 2) return 2;
      if (v > SIDE_CAP) return SIDE_CAP;
      return int'(v);
    endfunction

    function int pending();
      return expected_indices.size();
    endfunction

    function void write_reg(cfg_idx_t idx, side_t data);
      case (idx)
        CFG_GRID_WIDTH:  width_reg = data;
        CFG_GRID_HEIGHT: height_reg = data;
        CFG_MESH_MODE:   mode_reg = data[0];
        default:         return;
      endcase
      rewind();
    endfunction

    // Advance one tick and queue the index it emits
    function void note_tick(bit restart);
      int w, h, row, col, x, y, i, k, j;
      bit degen, fin, odd, top;
      logic [PHASE_W-1:0] c;
      result_t exp_word;
      w = used_side(width_reg);
      h = used_side(height_reg);
      row = 0;
      col = 0;
      degen = 0;
      fin = 0;
      if (restart) rewind();
      if (mode_reg == MODE_QUAD) begin
        x = col_cnt;
        y = row_cnt;
        if (x > w - 2 || y > h - 2) begin
          x = 0;
          y = 0;
        end
        c = corner[PHASE_W-1:0];
        case (c)
          CORNER_TL: begin row = y;     col = x;     end
          CORNER_BL: begin row = y + 1; col = x;     end
          CORNER_BR: begin row = y + 1; col = x + 1; end
          default:   begin row = y;     col = x + 1; end
        endcase
        if (c == CORNER_TR) begin
          fin = (x == w - 2 && y == h - 2);
          corner = 0;
          x++;
          if (x == w - 1) begin
            x = 0;
            y++;
            if (y == h - 1) y = 0;
          end
        end else begin
          corner = (corner + 1) & 3;
        end
        col_cnt = x;
        row_cnt = y;
        in_degen = 0;
      end else begin
        i = row_cnt;
        k = col_cnt;
        if (i > h - 2 || k > w - 1) begin
          i = 0;
          k = 0;
          in_degen = 0;
          corner = 0;
        end
        odd = i[0];
        if (in_degen) begin
          degen = 1;
          col = odd ? 0 : w - 1;
          if (corner[0] == 1'b0) begin
            row = odd ? i : i + 1;
            corner = 1;
          end else begin
            row = i + 1;
            corner = 0;
            in_degen = 0;
            i++;
            k = 0;
          end
        end else begin
          j = odd ? (w - 1 - k) : k;
          top = (corner[0] == 1'b0) != odd;
          row = top ? i : i + 1;
          col = j;
          if (corner[0] == 1'b0) begin
            corner = 1;
          end else begin
            corner = 0;
            k++;
            if (k == w) begin
              k = 0;
              if (i + 2 < h) begin
                in_degen = 1;
              end else begin
                fin = 1;
                i = 0;
              end
            end
          end
        end
        row_cnt = i;
        col_cnt = k;
      end
      exp_word.vertex_index  = index_t'(row * w + col);
      exp_word.vertex_column = coord_t'(col);
      exp_word.vertex_row    = coord_t'(row);
      exp_word.degenerate    = degen;
      exp_word.last          = fin;
      expected_indices = {expected_indices, exp_word};
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(result_t got);
      result_t exp_word;
      if (expected_indices.size() == 0) begin
        report($sformatf("unexpected index word %0d", got.vertex_index));
        return;
      end
      exp_word = expected_indices.pop_front();
      if (got.vertex_index !== exp_word.vertex_index)
        report($sformatf("vertex_index got %0d expected %0d",
                         got.vertex_index, exp_word.vertex_index));
      if (got.vertex_column !== exp_word.vertex_column)
        report($sformatf("vertex_column got %0d expected %0d",
                         got.vertex_column, exp_word.vertex_column));
      if (got.vertex_row !== exp_word.vertex_row)
        report($sformatf("vertex_row got %0d expected %0d",
                         got.vertex_row, exp_word.vertex_row));
      if (got.degenerate !== exp_word.degenerate)
        report($sformatf("degenerate got %b expected %b",
                         got.degenerate, exp_word.degenerate));
      if (got.last !== exp_word.last)
        report($sformatf("last got %b expected %b", got.last, exp_word.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] restart
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [15:0] vertex_index, [23:16] vertex_column, [31:24] vertex_row
  logic        out_tuser;  // [0] degenerate
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  side_t       cfg_data;

  mesh_index_scoreboard sb;
  bit calm;  // no idling on either side while set

  grid_mesh_index_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic side_t pick_side();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return side_t'($urandom_range(0, 1));
      1:       return side_t'($urandom_range(257, 511));
      2:       return side_t'($urandom_range(100, 256));
      3:       return 9'd256;
      default: return side_t'($urandom_range(2, 6));
    endcase
  endfunction

  // Sample every handshake at the edge
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[0]);
      if (out_tvalid && out_tready) begin
        got.vertex_index  = out_tdata[15:0];
        got.vertex_column = out_tdata[23:16];
        got.vertex_row    = out_tdata[31:24];
        got.degenerate    = out_tuser;
        got.last          = out_tlast;
        sb.check_word(got);
      end
    end
  end

  // Result sink with random backpressure
  initial begin : sink
    int n;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Hold the word until taken; valid stays high for a back-to-back word
  task automatic send_tick(bit restart);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Stop sending and wait until every expected word has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    // let the monitor note the last accepted word first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_word(cfg_idx_t idx, side_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic configure(side_t w, side_t h, logic mode, bit stray);
    cfg_word(CFG_GRID_WIDTH, w);
    if (stray) cfg_word(CFG_UNUSED, side_t'($urandom_range(0, 511)));
    cfg_word(CFG_GRID_HEIGHT, h);
    cfg_word(CFG_MESH_MODE, side_t'({8'd0, mode}));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sent, n;
    sb = new();
    calm = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: 2x2 strip, wrap past the end, restart mid-sequence
    repeat (6) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // Two strips with a degenerate pair between them, odd strip right to left
    configure(9'd2, 9'd3, MODE_STRIP, 1'b1);
    repeat (10) send_tick(1'b0);
    drain();

    // Quads with both sides saturated, restart on a quad corner
    configure(9'd1, 9'd511, MODE_QUAD, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      configure(pick_side(), pick_side(), logic'($urandom_range(0, 1)),
                $urandom_range(0, 7) == 0);
      n = $urandom_range(15, 90);
      repeat (n) begin
        send_tick($urandom_range(0, 99) < 4);
        sent++;
        if ($urandom_range(0, 99) < 2) drain();
      end
      drain();
    end

    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
